@@ design/bpi_pkg.sv @@
// Shared widths, command/status types and the Catmull-Rom weight function
// for the bicubic patch interpolator. No dependencies.
`default_nettype none

package bpi_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int ROW_W    = 2;
  localparam int OUT_W    = 18;
  localparam int ACC_W    = 56;
  localparam int NTAP     = 4;
  localparam int COL_W    = 2;

  // weights: Q2.FRAC_W signed with headroom for the intermediate sums
  localparam int WGT_W  = FRAC_W + 5;
  localparam int LO_W   = FRAC_W + 4;
  localparam int DOT_W  = SAMPLE_W + WGT_W + 2;
  localparam int HI_W   = DOT_W - LO_W;
  localparam int MUL_W  = WGT_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int TACC_W = DOT_W + WGT_W;
  localparam int TERM_W = TACC_W - FRAC_W;
  localparam int RND_W  = ACC_W + 1 - FRAC_W;

  localparam int unsigned HALF = 1 << (FRAC_W - 1);

  localparam logic signed [WGT_W-1:0] W_ONE = WGT_W'(1);
  localparam logic signed [WGT_W-1:0] W_TWO = WGT_W'(1) << (FRAC_W + 1);

  typedef logic [NTAP-1:0][WGT_W-1:0] wgt_vec_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_X2,
    OP_X3,
    OP_Y2,
    OP_Y3,
    OP_DOT,
    OP_TLO,
    OP_THI,
    OP_ACC,
    OP_OUT
  } op_e;

  typedef struct packed {
    logic             load;
    op_e              op;
    logic [COL_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic row_last;
  } status_t;

  // 0.5*(X*W) rounded half up, from f, f^2 and f^3 in Q0.FRAC_W
  function automatic wgt_vec_t calc_weights(input logic [FRAC_W-1:0] f,
                                            input logic [FRAC_W-1:0] f2,
                                            input logic [FRAC_W-1:0] f3);
    logic signed [WGT_W-1:0] e1, e2, e3;
    logic signed [WGT_W-1:0] n0, n1, n2, n3;
    logic signed [WGT_W-1:0] t0, t1, t2, t3;
    wgt_vec_t                w;
    e1 = signed'({{(WGT_W-FRAC_W){1'b0}}, f});
    e2 = signed'({{(WGT_W-FRAC_W){1'b0}}, f2});
    e3 = signed'({{(WGT_W-FRAC_W){1'b0}}, f3});
    n0 = (e2 <<< 1) - e1 - e3;
    n1 = W_TWO - ((e2 <<< 2) + e2) + ((e3 <<< 1) + e3);
    n2 = e1 + (e2 <<< 2) - ((e3 <<< 1) + e3);
    n3 = e3 - e2;
    t0 = n0 + W_ONE;
    t1 = n1 + W_ONE;
    t2 = n2 + W_ONE;
    t3 = n3 + W_ONE;
    w[0] = t0 >>> 1;
    w[1] = t1 >>> 1;
    w[2] = t2 >>> 1;
    w[3] = t3 >>> 1;
    return w;
  endfunction

endpackage

`default_nettype wire

@@ design/bpi_ctrl.sv @@
// Sequencer for the bicubic patch interpolator: steps the shared multiplier
// datapath through one row and owns both handshakes. Uses bpi_pkg.
`default_nettype none

module bpi_ctrl
  import bpi_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_X2   = 4'd1;
  localparam logic [3:0] ST_X3   = 4'd2;
  localparam logic [3:0] ST_Y2   = 4'd3;
  localparam logic [3:0] ST_Y3   = 4'd4;
  localparam logic [3:0] ST_D0   = 4'd5;
  localparam logic [3:0] ST_D1   = 4'd6;
  localparam logic [3:0] ST_D2   = 4'd7;
  localparam logic [3:0] ST_D3   = 4'd8;
  localparam logic [3:0] ST_TLO  = 4'd9;
  localparam logic [3:0] ST_THI  = 4'd10;
  localparam logic [3:0] ST_ACC  = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.load  = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.col   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_X2;
        end
      end
      ST_X2: begin
        cmd_o.op = OP_X2;
        state_d  = ST_X3;
      end
      ST_X3: begin
        cmd_o.op = OP_X3;
        state_d  = ST_Y2;
      end
      ST_Y2: begin
        cmd_o.op = OP_Y2;
        state_d  = ST_Y3;
      end
      ST_Y3: begin
        cmd_o.op = OP_Y3;
        state_d  = ST_D0;
      end
      ST_D0: begin
        cmd_o.op  = OP_DOT;
        cmd_o.col = COL_W'(0);
        state_d   = ST_D1;
      end
      ST_D1: begin
        cmd_o.op  = OP_DOT;
        cmd_o.col = COL_W'(1);
        state_d   = ST_D2;
      end
      ST_D2: begin
        cmd_o.op  = OP_DOT;
        cmd_o.col = COL_W'(2);
        state_d   = ST_D3;
      end
      ST_D3: begin
        cmd_o.op  = OP_DOT;
        cmd_o.col = COL_W'(3);
        state_d   = ST_TLO;
      end
      ST_TLO: begin
        cmd_o.op = OP_TLO;
        state_d  = ST_THI;
      end
      ST_THI: begin
        cmd_o.op = OP_THI;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        state_d  = status_i.row_last ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        // wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ design/bpi_datapath.sv @@
// Datapath for the bicubic patch interpolator: one shared 21x21 multiplier,
// cubic terms, weights, dot product, row accumulator and output rounding.
// Uses bpi_pkg.
`default_nettype none

module bpi_datapath
  import bpi_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cmd_t                       cmd_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_0_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_1_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_2_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_3_i,
  input  wire logic        [ROW_W-1:0]    row_index_i,
  input  wire logic        [FRAC_W-1:0]   x_frac_i,
  input  wire logic        [FRAC_W-1:0]   y_frac_i,
  output status_t                         status_o,
  output logic signed [OUT_W-1:0]         interpolated_o,
  output logic                            saturated_o
);

  logic signed [SAMPLE_W-1:0] s_q [NTAP];
  logic [ROW_W-1:0]           row_q;
  logic [FRAC_W-1:0]          x_q, y_q, x2_q, x3_q, y2_q, y3_q;
  logic signed [WGT_W-1:0]    wx_q [NTAP];
  logic signed [WGT_W-1:0]    wy_q;
  logic signed [DOT_W-1:0]    dot_q;
  logic signed [TACC_W-1:0]   tacc_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [OUT_W-1:0]    res_q, res_d;
  logic                       sat_q, sat_d;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_rnd;
  logic [FRAC_W-1:0]        cube_term;
  logic signed [DOT_W-1:0]  prod_dot;
  logic signed [TACC_W-1:0] prod_ext;
  logic [PROD_W+LO_W-1:0]   prod_shl;
  wgt_vec_t                 wx_all, wy_all;
  logic [TACC_W-1:0]        tacc_rnd;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  term_ext;
  logic [ACC_W:0]           acc_rnd;
  logic [RND_W-1:0]         v;
  logic [RND_W-OUT_W:0]     v_hi;
  logic                     in_range;

  assign status_o.row_last = (row_q == ROW_W'(NTAP - 1));

  assign wx_all = calc_weights(x_q, x2_q, x3_q);
  assign wy_all = calc_weights(y_q, y2_q, y3_q);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_X2: begin
        mul_a = signed'({{(MUL_W-FRAC_W){1'b0}}, x_q});
        mul_b = signed'({{(MUL_W-FRAC_W){1'b0}}, x_q});
      end
      OP_X3: begin
        mul_a = signed'({{(MUL_W-FRAC_W){1'b0}}, x2_q});
        mul_b = signed'({{(MUL_W-FRAC_W){1'b0}}, x_q});
      end
      OP_Y2: begin
        mul_a = signed'({{(MUL_W-FRAC_W){1'b0}}, y_q});
        mul_b = signed'({{(MUL_W-FRAC_W){1'b0}}, y_q});
      end
      OP_Y3: begin
        mul_a = signed'({{(MUL_W-FRAC_W){1'b0}}, y2_q});
        mul_b = signed'({{(MUL_W-FRAC_W){1'b0}}, y_q});
      end
      OP_DOT: begin
        mul_a = wx_q[cmd_i.col];
        mul_b = MUL_W'(s_q[cmd_i.col]);
      end
      OP_TLO: begin
        mul_a = signed'({{(MUL_W-LO_W){1'b0}}, dot_q[LO_W-1:0]});
        mul_b = wy_q;
      end
      OP_THI: begin
        mul_a = MUL_W'(signed'(dot_q[DOT_W-1:LO_W]));
        mul_b = wy_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign prod_rnd  = prod + PROD_W'(HALF);
  assign cube_term = prod_rnd[2*FRAC_W-1:FRAC_W];
  assign prod_dot  = prod[DOT_W-1:0];
  assign prod_ext  = TACC_W'(prod);
  assign prod_shl  = {prod, {LO_W{1'b0}}};

  // row term: (dot * wy + half) >>> FRAC_W, then accumulate
  assign tacc_rnd = tacc_q + TACC_W'(HALF);
  assign term     = signed'(tacc_rnd[TACC_W-1:FRAC_W]);
  assign term_ext = ACC_W'(term);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.op == OP_ACC) begin
      acc_d = (row_q == '0) ? term_ext : acc_q + term_ext;
    end
  end

  // output rounding and clipping
  assign acc_rnd  = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(HALF);
  assign v        = acc_rnd[ACC_W:FRAC_W];
  assign v_hi     = v[RND_W-1:OUT_W-1];
  assign in_range = (&v_hi) || !(|v_hi);

  always_comb begin
    sat_d = !in_range;
    if (in_range) begin
      res_d = signed'(v[OUT_W-1:0]);
    end else if (v[RND_W-1]) begin
      res_d = signed'({1'b1, {(OUT_W-1){1'b0}}});
    end else begin
      res_d = signed'({1'b0, {(OUT_W-1){1'b1}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q[0] <= sample_0_i;
      s_q[1] <= sample_1_i;
      s_q[2] <= sample_2_i;
      s_q[3] <= sample_3_i;
      row_q  <= row_index_i;
      x_q    <= x_frac_i;
      y_q    <= y_frac_i;
    end
    unique case (cmd_i.op)
      OP_X2: x2_q <= cube_term;
      OP_X3: x3_q <= cube_term;
      OP_Y2: begin
        y2_q <= cube_term;
        for (int i = 0; i < NTAP; i++) begin
          wx_q[i] <= signed'(wx_all[i]);
        end
      end
      OP_Y3: y3_q <= cube_term;
      OP_DOT: begin
        if (cmd_i.col == '0) begin
          dot_q <= prod_dot;
          wy_q  <= signed'(wy_all[row_q]);
        end else begin
          dot_q <= dot_q + prod_dot;
        end
      end
      OP_TLO: tacc_q <= prod_ext;
      OP_THI: tacc_q <= tacc_q + signed'(prod_shl[TACC_W-1:0]);
      OP_OUT: begin
        res_q <= res_d;
        sat_q <= sat_d;
      end
      default: begin
      end
    endcase
  end

  assign interpolated_o = res_q;
  assign saturated_o    = sat_q;

endmodule

`default_nettype wire

@@ design/bicubic_patch_interpolator.sv @@
// Catmull-Rom bicubic patch interpolator, one patch row per input transfer.
// A new row is accepted only once the sequencer is back in idle; a shared 21x21
// multiplier is stepped through cubic terms, four taps and the y scaling.
// The result of a row-3 transfer is registered in the output register, and
// waits while that register is still held. Reset: sequencer idle, output
// empty, row accumulator zero.
`default_nettype none

module bicubic_patch_interpolator
  import bpi_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_0_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_1_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_2_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_3_i,
  input  wire logic        [ROW_W-1:0]    row_index_i,
  input  wire logic        [FRAC_W-1:0]   x_frac_i,
  input  wire logic        [FRAC_W-1:0]   y_frac_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [OUT_W-1:0]         interpolated_o,
  output logic                            saturated_o
);

  cmd_t    cmd;
  status_t status;

  bpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bpi_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sample_0_i     (sample_0_i),
    .sample_1_i     (sample_1_i),
    .sample_2_i     (sample_2_i),
    .sample_3_i     (sample_3_i),
    .row_index_i    (row_index_i),
    .x_frac_i       (x_frac_i),
    .y_frac_i       (y_frac_i),
    .status_o       (status),
    .interpolated_o (interpolated_o),
    .saturated_o    (saturated_o)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for bicubic_patch_interpolator: directed corner patches,
// then random patch rows under four handshake idling phases.
// Depends on bpi_pkg and the interpolator RTL only.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bpi_pkg::*;

  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     DRAIN_CYCLES = 40;
  localparam longint RND_HALF     = longint'(1) << (FRAC_W - 1);
  localparam longint OUT_HI       = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_LO       = -(OUT_HI + 1);

  localparam logic signed [SAMPLE_W-1:0] S_MAX = SAMPLE_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [SAMPLE_W-1:0] S_MIN = SAMPLE_W'(-(2 ** (SAMPLE_W - 1)));
  localparam logic [ROW_W-1:0]           FIRST_ROW = '0;
  localparam logic [ROW_W-1:0]           LAST_ROW  = ROW_W'(NTAP - 1);

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct {
    logic signed [SAMPLE_W-1:0] s0, s1, s2, s3;
    logic [ROW_W-1:0]           row;
    logic [FRAC_W-1:0]          x, y;
  } row_item_t;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    sat;
  } pixel_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b1;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_0_i = '0;
  logic signed [SAMPLE_W-1:0] sample_1_i = '0;
  logic signed [SAMPLE_W-1:0] sample_2_i = '0;
  logic signed [SAMPLE_W-1:0] sample_3_i = '0;
  logic [ROW_W-1:0]           row_index_i = '0;
  logic [FRAC_W-1:0]          x_frac_i = '0;
  logic [FRAC_W-1:0]          y_frac_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [OUT_W-1:0]    interpolated_o;
  logic                       saturated_o;

  idle_e                   idle_mode = IDLE_NONE;
  logic signed [ACC_W-1:0] patch_sum = '0;
  pixel_t                  pending_pixels[$];
  int                      errors = 0;
  int                      cycle = 0;
  int                      rows_sent = 0;
  int                      pixels_seen = 0;
  int                      clipped_seen = 0;

  bicubic_patch_interpolator dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sample_0_i,
    .sample_1_i,
    .sample_2_i,
    .sample_3_i,
    .row_index_i,
    .x_frac_i,
    .y_frac_i,
    .out_valid_o,
    .out_ready_i,
    .interpolated_o,
    .saturated_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle++;
    if (cycle == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle,
               pending_pixels.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned idle_pct(input bit sender);
    case (idle_mode)
      IDLE_SEND: return sender ? 68 : 0;
      IDLE_RECV: return sender ? 0 : 68;
      IDLE_BOTH: return 18;
      default:   return 0;
    endcase
  endfunction

  // Catmull-Rom weight for one tap, 0.5*(X*W) rounded half up, signed Q2.F
  function automatic longint cubic_weight(input logic [FRAC_W-1:0] f, input int tap);
    longint x, x2, x3, n;
    x  = longint'(f);
    x2 = (x * x + RND_HALF) >>> FRAC_W;
    x3 = (x2 * x + RND_HALF) >>> FRAC_W;
    case (tap)
      0:       n = 2 * x2 - x - x3;
      1:       n = 2 * (longint'(1) << FRAC_W) - 5 * x2 + 3 * x3;
      2:       n = x + 4 * x2 - 3 * x3;
      default: n = x3 - x2;
    endcase
    return (n + 1) >>> 1;
  endfunction

  function automatic void interpolate_row(input row_item_t r);
    longint                  dot, term, rounded;
    logic signed [ACC_W-1:0] nxt;
    pixel_t                  px;
    dot = cubic_weight(r.x, 0) * longint'(r.s0) + cubic_weight(r.x, 1) * longint'(r.s1)
        + cubic_weight(r.x, 2) * longint'(r.s2) + cubic_weight(r.x, 3) * longint'(r.s3);
    term = (dot * cubic_weight(r.y, int'(r.row)) + RND_HALF) >>> FRAC_W;
    if (r.row == FIRST_ROW) begin
      nxt = ACC_W'(term);
    end else begin
      nxt = patch_sum + ACC_W'(term);
    end
    patch_sum = nxt;
    if (r.row == LAST_ROW) begin
      rounded = (longint'(nxt) + RND_HALF) >>> FRAC_W;
      px.sat  = (rounded > OUT_HI) || (rounded < OUT_LO);
      if (rounded > OUT_HI) begin
        px.value = OUT_W'(OUT_HI);
      end else if (rounded < OUT_LO) begin
        px.value = OUT_W'(OUT_LO);
      end else begin
        px.value = OUT_W'(rounded);
      end
      pending_pixels.push_back(px);
    end
  endfunction

  function automatic row_item_t make_row(input logic signed [SAMPLE_W-1:0] s0, s1, s2, s3,
                                         input logic [ROW_W-1:0] row,
                                         input logic [FRAC_W-1:0] x, y);
    row_item_t r;
    r.s0  = s0;
    r.s1  = s1;
    r.s2  = s2;
    r.s3  = s3;
    r.row = row;
    r.x   = x;
    r.y   = y;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return S_MIN;
      1:       return S_MAX;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] rand_frac();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) $display("mismatch at cycle %0d: %s", cycle, msg);
  endtask

  // one row transfer; returns at the edge that accepted it, valid still high
  task automatic send_row(input row_item_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct(1'b1)) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_0_i  <= r.s0;
    sample_1_i  <= r.s1;
    sample_2_i  <= r.s2;
    sample_3_i  <= r.s3;
    row_index_i <= r.row;
    x_frac_i    <= r.x;
    y_frac_i    <= r.y;
    do @(posedge clk_i); while (!in_ready_o);
    interpolate_row(r);
    rows_sent++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
  endtask

  always @(posedge clk_i) begin : result_check
    pixel_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        report($sformatf("result %0d with nothing expected", interpolated_o));
      end else begin
        want = pending_pixels.pop_front();
        pixels_seen++;
        if (want.sat) clipped_seen++;
        if (interpolated_o !== want.value)
          report($sformatf("interpolated %0d, expected %0d", interpolated_o, want.value));
        if (saturated_o !== want.sat)
          report($sformatf("saturated %0b, expected %0b", saturated_o, want.sat));
      end
    end
    out_ready_i <= ($urandom_range(99) >= idle_pct(1'b0));
  end

  task automatic test_directed_corners();
    idle_mode = IDLE_NONE;
    // full-scale patches at both ends of the fraction range and at the midpoint
    for (int k = 0; k < NTAP; k++)
      send_row(make_row(S_MAX, S_MAX, S_MAX, S_MAX, ROW_W'(k), '0, '0));
    for (int k = 0; k < NTAP; k++)
      send_row(make_row(S_MIN, S_MIN, S_MIN, S_MIN, ROW_W'(k), '1, '1));
    for (int k = 0; k < NTAP; k++) begin
      if (k[0]) send_row(make_row(S_MAX, S_MIN, S_MIN, S_MAX, ROW_W'(k), 16'h8000, 16'h8000));
      else      send_row(make_row(S_MIN, S_MAX, S_MAX, S_MIN, ROW_W'(k), 16'h8000, 16'h8000));
    end
    // repeated rows pile up past full scale: clip high
    send_row(make_row('0, '0, '0, '0, FIRST_ROW, '0, '0));
    repeat (5) send_row(make_row('0, S_MAX, '0, '0, ROW_W'(1), '0, '0));
    send_row(make_row('0, '0, '0, '0, LAST_ROW, '0, '0));
    // lands exactly on the negative limit, then row 3 again reuses the held sum
    send_row(make_row('0, '0, '0, '0, FIRST_ROW, '0, '0));
    repeat (4) send_row(make_row('0, S_MIN, '0, '0, ROW_W'(1), '0, '0));
    send_row(make_row('0, '0, '0, '0, LAST_ROW, '0, '0));
    send_row(make_row('0, '0, '0, '0, LAST_ROW, '0, '0));
  endtask

  task automatic test_random_patches(input idle_e mode, input int target);
    int                         goal, pick, len;
    logic [FRAC_W-1:0]          x, y;
    logic signed [SAMPLE_W-1:0] e;
    idle_mode = mode;
    goal = rows_sent + target;
    while (rows_sent < goal) begin
      pick = $urandom_range(99);
      x = rand_frac();
      y = rand_frac();
      if (pick < 80) begin
        for (int k = 0; k < NTAP; k++)
          send_row(make_row(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                            ROW_W'(k), x, y));
      end else if (pick < 92) begin
        send_row(make_row(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                          ROW_W'($urandom_range(NTAP - 1)), x, y));
      end else begin
        // long run of same-sign middle rows, usually drives the sum into clipping
        e   = $urandom_range(1) ? S_MAX : S_MIN;
        len = $urandom_range(4, 9);
        send_row(make_row(e, e, e, e, FIRST_ROW, x, y));
        repeat (len) send_row(make_row(e, e, e, e, ROW_W'($urandom_range(1, 2)), x, y));
        send_row(make_row(e, e, e, e, LAST_ROW, x, y));
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_random_patches(IDLE_NONE, 240);
    wait_for_results();
    test_random_patches(IDLE_SEND, 230);
    test_random_patches(IDLE_RECV, 230);
    wait_for_results();
    test_random_patches(IDLE_BOTH, 230);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d patch rows across four idling phases, including repeated and",
             rows_sent);
    $display("out-of-order rows; %0d results checked, %0d of them clipped",
             pixels_seen, clipped_seen);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
design/bpi_pkg.sv
design/bpi_ctrl.sv
design/bpi_datapath.sv
design/bicubic_patch_interpolator.sv
tb/testbench.sv
